>>> src/itp_pkg.sv
`timescale 1ns / 1ps

package itp_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned ELAPSED_W = 20;
    localparam int unsigned NS_W      = 26;
    localparam int unsigned RELOAD_W  = 16;
    localparam int unsigned REM_W     = 21;

    // input clock of the counter and nanoseconds per second
    localparam longint unsigned PIT_HZ     = 64'd1193182;
    localparam longint unsigned NS_PER_SEC = 64'd1000000000;
    localparam longint unsigned FULL_COUNT = 64'd65536;

    localparam logic [NS_W-1:0]  FULL_COUNT_NS = NS_W'(FULL_COUNT * NS_PER_SEC / PIT_HZ);
    localparam logic [REM_W-1:0] PIT_HZ_R      = REM_W'(PIT_HZ);

    typedef enum logic [1:0] {
        OP_READ    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_ADVANCE = 2'd2,
        OP_TAKE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        PORT_CTRL = 2'd0,
        PORT_CH0  = 2'd1,
        PORT_CH2  = 2'd2,
        PORT_GATE = 2'd3
    } port_t;

    localparam logic [1:0]        CHAN_0       = 2'd0;
    localparam logic [1:0]        CHAN_2       = 2'd2;
    localparam logic [2:0]        MODE_SQUARE  = 3'd3;
    localparam logic [BYTE_W-1:0] BIT_TERMINAL = 8'h20;
    localparam logic [BYTE_W-1:0] BIT_GATE     = 8'h01;

    typedef logic [255:0][NS_W-1:0]  quot_tbl_t;
    typedef logic [255:0][REM_W-1:0] rem_tbl_t;

    // count * 1e9 split as high byte and low byte, each kept as quotient and
    // remainder of the division by the input clock rate
    function automatic quot_tbl_t build_quot(input longint unsigned weight);
        quot_tbl_t       t;
        longint unsigned p;
        for (int i = 0; i < 256; i++) begin
            p    = 64'(i) * weight * NS_PER_SEC;
            t[i] = NS_W'(p / PIT_HZ);
        end
        return t;
    endfunction

    function automatic rem_tbl_t build_rem(input longint unsigned weight);
        rem_tbl_t        t;
        longint unsigned p;
        for (int i = 0; i < 256; i++) begin
            p    = 64'(i) * weight * NS_PER_SEC;
            t[i] = REM_W'(p % PIT_HZ);
        end
        return t;
    endfunction

    localparam quot_tbl_t QUOT_HI = build_quot(64'd256);
    localparam quot_tbl_t QUOT_LO = build_quot(64'd1);
    localparam rem_tbl_t  REM_HI  = build_rem(64'd256);
    localparam rem_tbl_t  REM_LO  = build_rem(64'd1);

    // truncated count-to-ns, a count of zero meaning the full 65536
    function automatic logic [NS_W-1:0] ticks_to_ns(input logic [RELOAD_W-1:0] count);
        logic [NS_W-1:0]  q;
        logic [REM_W:0]   r;
        q = QUOT_HI[count[15:8]] + QUOT_LO[count[7:0]];
        r = {1'b0, REM_HI[count[15:8]]} + {1'b0, REM_LO[count[7:0]]};
        if (r >= {1'b0, PIT_HZ_R}) begin
            q = q + NS_W'(1);
        end
        if (count == '0) begin
            q = FULL_COUNT_NS;
        end
        return q;
    endfunction

endpackage

>>> src/interval_timer_ports.sv
`timescale 1ns / 1ps

// interval_timer_ports: reduced two-channel interval timer seen through four
// byte-wide ports (control, channel 0 count, channel 2 count, gate).
// input channel s_axis_*: one item is a port read, a port write, a time
// advance or a take of the pending expiry edge; tuser carries the opcode and
// port select, tdata carries the write byte and the nanoseconds to add.
// result channel m_axis_*: exactly one item per input item, in order, with
// the read byte, the taken edge flag and channel 0's square-wave period.
// registered: each result enters the result register, or the skid register while
// that is still occupied, when its input item is accepted. throughput: one item per cycle
// while the skid register is empty; the count-to-ns conversion is four 256-entry
// constant tables plus adds and a compare, combinational before the result register.
// stall: a two-entry output (result register plus skid register) keeps
// s_axis_tready high while one result waits; tready drops only once the
// skid register is also full, and rises again the cycle after it drains.
// reset: aresetn low at a clock edge clears all timer state to power-up values
// (both channels expecting a low byte, gate off, channel 2 disarmed, no edge
// pending) and empties the output stage.
module interval_timer_ports (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // write_byte[7:0], elapsed_ns[27:8], zero fill
    input  logic [3:0]  s_axis_tuser,   // opcode[1:0], port_sel[3:2]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // read_data[7:0], edge_taken[8],
                                        // ch0_periodic[9], ch0_period_ns[35:10], zero fill
);
    import itp_pkg::*;

    localparam int unsigned RES_W = BYTE_W + 2 + NS_W;

    // item fields
    op_t                  opcode;
    port_t                port_sel;
    logic [BYTE_W-1:0]    write_byte;
    logic [ELAPSED_W-1:0] elapsed_ns;

    assign opcode     = op_t'(s_axis_tuser[1:0]);
    assign port_sel   = port_t'(s_axis_tuser[3:2]);
    assign write_byte = s_axis_tdata[7:0];
    assign elapsed_ns = s_axis_tdata[27:8];

    // timer state
    logic                gate_enable_reg,     gate_enable_next;
    logic                ch0_expect_low_reg,  ch0_expect_low_next;
    logic                ch0_square_mode_reg, ch0_square_mode_next;
    logic [RELOAD_W-1:0] ch0_reload_reg,      ch0_reload_next;
    logic                ch2_expect_low_reg,  ch2_expect_low_next;
    logic [RELOAD_W-1:0] ch2_reload_reg,      ch2_reload_next;
    logic                ch2_armed_reg,       ch2_armed_next;
    logic [NS_W-1:0]     ch2_interval_reg,    ch2_interval_next;
    logic [NS_W-1:0]     ch2_elapsed_reg,     ch2_elapsed_next;
    logic                ch2_seen_reg,        ch2_seen_next;
    logic                edge_pending_reg,    edge_pending_next;

    // output stage
    logic             out_valid_reg,  out_valid_next;
    logic [RES_W-1:0] out_data_reg,   out_data_next;
    logic             skid_valid_reg, skid_valid_next;
    logic [RES_W-1:0] skid_data_reg,  skid_data_next;

    logic             accept;
    logic             take;
    logic [RES_W-1:0] result;
    logic [BYTE_W-1:0] read_data;
    logic             edge_taken;
    logic             expired;
    logic [NS_W:0]    elapsed_sum;
    logic [RELOAD_W-1:0] ch2_reload_hi;
    logic [NS_W-1:0]  ch0_period_ns;

    assign s_axis_tready = !skid_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign take          = out_valid_reg && m_axis_tready;

    assign expired       = ch2_armed_reg && (ch2_elapsed_reg >= ch2_interval_reg);
    assign elapsed_sum   = {1'b0, ch2_elapsed_reg} + (NS_W + 1)'(elapsed_ns);
    assign ch2_reload_hi = {write_byte, ch2_reload_reg[7:0]};

    // per-item state update and result
    always_comb begin
        gate_enable_next     = gate_enable_reg;
        ch0_expect_low_next  = ch0_expect_low_reg;
        ch0_square_mode_next = ch0_square_mode_reg;
        ch0_reload_next      = ch0_reload_reg;
        ch2_expect_low_next  = ch2_expect_low_reg;
        ch2_reload_next      = ch2_reload_reg;
        ch2_armed_next       = ch2_armed_reg;
        ch2_interval_next    = ch2_interval_reg;
        ch2_elapsed_next     = ch2_elapsed_reg;
        ch2_seen_next        = ch2_seen_reg;
        edge_pending_next    = edge_pending_reg;
        read_data            = '0;
        edge_taken           = 1'b0;

        case (opcode)
            OP_READ: begin
                if (port_sel == PORT_GATE) begin
                    read_data = gate_enable_reg ? BIT_GATE : '0;
                    if (expired) begin
                        read_data = read_data | BIT_TERMINAL;
                        if (!ch2_seen_reg) begin
                            ch2_seen_next     = 1'b1;
                            edge_pending_next = 1'b1;
                        end
                    end
                end
            end
            OP_WRITE: begin
                case (port_sel)
                    PORT_CTRL: begin
                        if (write_byte[7:6] == CHAN_0) begin
                            ch0_expect_low_next  = 1'b1;
                            ch0_square_mode_next = (write_byte[3:1] == MODE_SQUARE);
                        end else if (write_byte[7:6] == CHAN_2) begin
                            ch2_expect_low_next = 1'b1;
                            ch2_armed_next      = 1'b0;
                        end
                    end
                    PORT_CH0: begin
                        if (ch0_expect_low_reg) begin
                            ch0_reload_next     = RELOAD_W'(write_byte);
                            ch0_expect_low_next = 1'b0;
                        end else begin
                            ch0_reload_next     = {write_byte, ch0_reload_reg[7:0]};
                            ch0_expect_low_next = 1'b1;
                        end
                    end
                    PORT_CH2: begin
                        if (ch2_expect_low_reg) begin
                            ch2_reload_next     = RELOAD_W'(write_byte);
                            ch2_expect_low_next = 1'b0;
                        end else begin
                            ch2_reload_next     = ch2_reload_hi;
                            ch2_expect_low_next = 1'b1;
                            // arm and restart only with the gate on
                            if (gate_enable_reg) begin
                                ch2_elapsed_next  = '0;
                                ch2_interval_next = ticks_to_ns(ch2_reload_hi);
                                ch2_armed_next    = 1'b1;
                                ch2_seen_next     = 1'b0;
                            end
                        end
                    end
                    PORT_GATE: begin
                        gate_enable_next = write_byte[0];
                    end
                    default: begin
                        gate_enable_next = gate_enable_reg;
                    end
                endcase
            end
            OP_ADVANCE: begin
                // saturating elapsed time
                ch2_elapsed_next = elapsed_sum[NS_W] ? '1 : elapsed_sum[NS_W-1:0];
            end
            OP_TAKE: begin
                edge_taken        = edge_pending_reg;
                edge_pending_next = 1'b0;
            end
            default: begin
                read_data = '0;
            end
        endcase

        ch0_period_ns = ch0_square_mode_next ? ticks_to_ns(ch0_reload_next) : '0;
        result        = {ch0_period_ns, ch0_square_mode_next, edge_taken, read_data};
    end

    // result register with a skid register behind it
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (take) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = 1'b0;
            end
        end
        if (accept) begin
            if (!out_valid_reg || take) begin
                out_valid_next = 1'b1;
                out_data_next  = result;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = result;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gate_enable_reg     <= 1'b0;
            ch0_expect_low_reg  <= 1'b1;
            ch0_square_mode_reg <= 1'b0;
            ch0_reload_reg      <= '0;
            ch2_expect_low_reg  <= 1'b1;
            ch2_reload_reg      <= '0;
            ch2_armed_reg       <= 1'b0;
            ch2_interval_reg    <= '0;
            ch2_elapsed_reg     <= '0;
            ch2_seen_reg        <= 1'b0;
            edge_pending_reg    <= 1'b0;
            out_valid_reg       <= 1'b0;
            skid_valid_reg      <= 1'b0;
        end else begin
            if (accept) begin
                gate_enable_reg     <= gate_enable_next;
                ch0_expect_low_reg  <= ch0_expect_low_next;
                ch0_square_mode_reg <= ch0_square_mode_next;
                ch0_reload_reg      <= ch0_reload_next;
                ch2_expect_low_reg  <= ch2_expect_low_next;
                ch2_reload_reg      <= ch2_reload_next;
                ch2_armed_reg       <= ch2_armed_next;
                ch2_interval_reg    <= ch2_interval_next;
                ch2_elapsed_reg     <= ch2_elapsed_next;
                ch2_seen_reg        <= ch2_seen_next;
                edge_pending_reg    <= edge_pending_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(40 - RES_W)'(0), out_data_reg};

endmodule

>>> src/itp_checker.sv
`timescale 1ns / 1ps

module itp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    // output stage empty after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // period reported only in square-wave mode
    a_period_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[9] |-> m_axis_tdata[35:10] == 26'd0)
        else $error("period nonzero while not periodic");

    // read byte carries only gate and terminal bits
    a_read_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[7:0] & 8'hde) == 8'h00)
        else $error("unexpected read bits");

    // a taken edge never comes with read data
    a_take_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tdata[7:0] == 8'h00)
        else $error("edge taken on a read item");

endmodule

bind interval_timer_ports itp_checker u_itp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
